// ===== src/mast_pkg.sv =====
// Shared types and constants for the motor axis sync tracker.
package mast_pkg;

  typedef logic signed [9:0] pos_t;
  typedef logic signed [10:0] err_t;
  typedef logic [9:0] mag_t;
  typedef logic [2:0] accel_t;
  typedef logic [31:0] ms_t;
  typedef logic [15:0] timeout_t;
  typedef logic [15:0] prod_t;
  typedef logic [0:0] cfg_idx_t;
  typedef logic [15:0] cfg_data_t;

  localparam cfg_idx_t CFG_SYNC_RANGE   = 1'b0;
  localparam cfg_idx_t CFG_SYNC_TIMEOUT = 1'b1;

  localparam mag_t     RANGE_RESET   = 10'd5;
  localparam timeout_t TIMEOUT_RESET = 16'd2000;

  localparam mag_t ACCEL_LIM_1 = 10'd750;
  localparam mag_t ACCEL_LIM_2 = 10'd500;
  localparam mag_t ACCEL_LIM_3 = 10'd250;

  localparam prod_t RECIP_3     = 16'd43691;
  localparam int    RECIP_SHIFT = 17;

  typedef struct packed {
    pos_t   set_point;
    ms_t    now_ms;
    mag_t   mag;
    pos_t   half;
    accel_t accel;
  } req_t;

  typedef struct packed {
    logic valid;
    req_t req;
  } q_push_t;

  typedef struct packed {
    logic valid;
    logic full;
  } q_stat_t;

endpackage

// ===== src/mast_if.sv =====
// Request and result channel interfaces.
interface mast_in_if;
  logic              valid;
  logic              ready;
  mast_pkg::pos_t    set_point;
  mast_pkg::pos_t    actual_value;
  mast_pkg::ms_t     now_ms;

  modport source (output valid, output set_point, output actual_value, output now_ms,
                  input ready);
  modport sink   (input valid, input set_point, input actual_value, input now_ms,
                  output ready);
endinterface

interface mast_out_if;
  logic              valid;
  logic              ready;
  mast_pkg::pos_t    step_command;
  logic              in_move;
  logic              synchronized;
  logic              sync_press;

  modport source (output valid, output step_command, output in_move, output synchronized,
                  output sync_press, input ready);
  modport sink   (input valid, input step_command, input in_move, input synchronized,
                  input sync_press, output ready);
endinterface

// ===== src/mast_front.sv =====
// Front end: accepts requests, computes error, half step and acceleration class.
module mast_front (
  mast_in_if.sink          in_ch,
  input  mast_pkg::q_stat_t q_stat,
  output mast_pkg::q_push_t q_push
);
  import mast_pkg::*;

  err_t err;
  err_t err_abs;
  err_t err_rnd;
  mag_t mag;

  always_comb begin
    err     = err_t'(in_ch.set_point) - err_t'(in_ch.actual_value);
    err_abs = err[10] ? -err : err;
    err_rnd = err + $signed({10'b0, err[10]});
    mag     = err_abs[9:0];
  end

  assign in_ch.ready = !q_stat.full;

  always_comb begin
    q_push.valid         = in_ch.valid && !q_stat.full;
    q_push.req.set_point = in_ch.set_point;
    q_push.req.now_ms    = in_ch.now_ms;
    q_push.req.mag       = mag;
    q_push.req.half      = err_rnd[10:1];
    q_push.req.accel     = 3'd1 + {2'b0, mag <= ACCEL_LIM_1} + {2'b0, mag <= ACCEL_LIM_2}
                         + {2'b0, mag <= ACCEL_LIM_3} + {2'b0, mag == 10'd0};
  end

endmodule

// ===== src/mast_queue.sv =====
// Request queue between front end and back end.
module mast_queue #(
  parameter int DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  mast_pkg::q_push_t q_push,
  output mast_pkg::q_stat_t q_stat,
  output mast_pkg::req_t    pop_req,
  input  logic              pop_ready
);
  import mast_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  req_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             push;
  logic             pop;

  assign q_stat.valid = cnt_r != '0;
  assign q_stat.full  = cnt_r == CNT_FULL;
  assign pop_req      = mem_r[rd_ptr_r];
  assign push         = q_push.valid && !q_stat.full;
  assign pop          = pop_ready && q_stat.valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= q_push.req;
    end
  end

endmodule

// ===== src/mast_back.sv =====
// Back end: move deadline, sync tracking and result register.
module mast_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               pop_valid,
  input  mast_pkg::req_t     pop_req,
  output logic               pop_ready,
  input  mast_pkg::mag_t     sync_range,
  input  mast_pkg::timeout_t sync_timeout,
  mast_out_if.source         out_ch
);
  import mast_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_UPD  = 4'b1000
  } back_state_t;

  back_state_t state_r, state_nxt;
  req_t        item_r, item_nxt;
  prod_t       prod_r, prod_nxt;
  ms_t         quot_r, quot_nxt;

  pos_t prev_target_r, prev_target_nxt;
  ms_t  deadline_r, deadline_nxt;
  logic moving_r, moving_nxt;
  logic sync_r, sync_nxt;
  ms_t  last_sync_r, last_sync_nxt;

  logic out_valid_r, out_valid_nxt;
  pos_t out_step_r, out_step_nxt;
  logic out_move_r, out_move_nxt;
  logic out_sync_r, out_sync_nxt;
  logic out_press_r, out_press_nxt;

  logic [12:0] mag_accel;
  ms_t         dur;
  ms_t         elapsed;
  logic        changed;
  logic        press;
  logic        slot_free;

  assign out_ch.valid        = out_valid_r;
  assign out_ch.step_command = out_step_r;
  assign out_ch.in_move      = out_move_r;
  assign out_ch.synchronized = out_sync_r;
  assign out_ch.sync_press   = out_press_r;

  assign slot_free = !out_valid_r || out_ch.ready;

  always_comb begin
    state_nxt       = state_r;
    item_nxt        = item_r;
    prod_nxt        = prod_r;
    quot_nxt        = quot_r;
    prev_target_nxt = prev_target_r;
    deadline_nxt    = deadline_r;
    moving_nxt      = moving_r;
    sync_nxt        = sync_r;
    last_sync_nxt   = last_sync_r;
    out_valid_nxt   = out_valid_r && !out_ch.ready;
    out_step_nxt    = out_step_r;
    out_move_nxt    = out_move_r;
    out_sync_nxt    = out_sync_r;
    out_press_nxt   = out_press_r;
    pop_ready       = 1'b0;
    mag_accel       = 13'({3'b0, item_r.mag} * {10'b0, item_r.accel});
    dur             = quot_r >> RECIP_SHIFT;
    elapsed         = item_r.now_ms - last_sync_r;
    changed         = prev_target_r != item_r.set_point;
    press           = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        pop_ready = 1'b1;
        if (pop_valid) begin
          item_nxt  = pop_req;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        prod_nxt  = ({3'b0, mag_accel} << 3) + ({3'b0, mag_accel} << 1);
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        quot_nxt  = {16'b0, prod_r} * {16'b0, RECIP_3};
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        if (slot_free) begin
          if (changed) begin
            prev_target_nxt = item_r.set_point;
            moving_nxt      = 1'b1;
            deadline_nxt    = item_r.now_ms + dur;
          end
          if (deadline_nxt < item_r.now_ms) begin
            moving_nxt = 1'b0;
          end
          if (item_r.mag < sync_range) begin
            sync_nxt      = 1'b1;
            last_sync_nxt = item_r.now_ms;
          end else if (elapsed >= {16'b0, sync_timeout} && sync_r && !moving_nxt) begin
            sync_nxt = 1'b0;
            press    = 1'b1;
          end
          out_valid_nxt = 1'b1;
          out_step_nxt  = item_r.half;
          out_move_nxt  = moving_nxt;
          out_sync_nxt  = sync_nxt;
          out_press_nxt = press;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      prev_target_r <= '0;
      deadline_r    <= '0;
      moving_r      <= 1'b0;
      sync_r        <= 1'b0;
      last_sync_r   <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      prev_target_r <= prev_target_nxt;
      deadline_r    <= deadline_nxt;
      moving_r      <= moving_nxt;
      sync_r        <= sync_nxt;
      last_sync_r   <= last_sync_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r      <= item_nxt;
    prod_r      <= prod_nxt;
    quot_r      <= quot_nxt;
    out_step_r  <= out_step_nxt;
    out_move_r  <= out_move_nxt;
    out_sync_r  <= out_sync_nxt;
    out_press_r <= out_press_nxt;
  end

`ifndef NO_ASSERTIONS
  a_press_drops_sync: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_press_r |-> !out_sync_r && !out_move_r)
    else $error("sync press with sync or move still set");

  a_result_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_UPD && slot_free |=> out_valid_r && out_sync_r == sync_r
      && out_move_r == moving_r)
    else $error("result flags differ from tracked state");

  a_step_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_step_r != -10'sd512)
    else $error("step command out of range");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop_ready |-> state_r == ST_IDLE)
    else $error("request taken while busy");
`endif

endmodule

// ===== src/motor_axis_sync_tracker.sv =====
// Top level of the motor axis sync tracker: config registers and block wiring.
//
//   channel  dir  handshake         payload
//   in_ch    in   valid/ready       set_point, actual_value, now_ms
//   out_ch   out  valid/ready       step_command, in_move, synchronized, sync_press
//   cfg_*    in   cfg_we            cfg_addr, cfg_wdata
//
// In the back end each request goes through fetch, multiply, reciprocal
// multiply by 1/3 and state update; the back end handles one request at a time.
// Requests enter the queue in the cycle they arrive while it has room.
// A stalled result holds in the output register; the update step waits for it.
// Reset clears the tracking state and loads range 5 and timeout 2000 ms.
module motor_axis_sync_tracker #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  mast_in_if.sink             in_ch,
  mast_out_if.source          out_ch,
  input  logic                cfg_we,
  input  mast_pkg::cfg_idx_t  cfg_addr,
  input  mast_pkg::cfg_data_t cfg_wdata
);
  import mast_pkg::*;

  mag_t     sync_range_r;
  timeout_t sync_timeout_r;
  q_push_t  q_push;
  q_stat_t  q_stat;
  req_t     pop_req;
  logic     pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_range_r   <= RANGE_RESET;
      sync_timeout_r <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_SYNC_RANGE:   sync_range_r   <= cfg_wdata[9:0];
        CFG_SYNC_TIMEOUT: sync_timeout_r <= cfg_wdata;
      endcase
    end
  end

  mast_front u_front (
    .in_ch  (in_ch),
    .q_stat (q_stat),
    .q_push (q_push)
  );

  mast_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_push    (q_push),
    .q_stat    (q_stat),
    .pop_req   (pop_req),
    .pop_ready (pop_ready)
  );

  mast_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .pop_valid    (q_stat.valid),
    .pop_req      (pop_req),
    .pop_ready    (pop_ready),
    .sync_range   (sync_range_r),
    .sync_timeout (sync_timeout_r),
    .out_ch       (out_ch)
  );

endmodule
